FILE: design/wrp_pkg.sv
// shared types and constants for the weighted random picker
package wrp_pkg;

    // targets that have a weight register
    localparam int MAX_TARGETS = 4;

    typedef logic [1:0] status_t;
    typedef logic [2:0] cfg_index_t;

    // result status codes
    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_OVERFLOW = 2'd1;
    localparam status_t STATUS_ZERO     = 2'd2;

    // configuration register indexes
    localparam cfg_index_t REG_CLUSTER_COUNT = 3'd0;
    localparam cfg_index_t REG_WEIGHT_0      = 3'd1;

    // field widths
    localparam int RANDOM_W = 64;
    localparam int WEIGHT_W = 32;

endpackage

FILE: design/weighted_random_picker_with_exclusion_core.sv
// weighted random target picker with exclusion of used targets
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------------
//  cfg     | in  | cfg_valid/cfg_ready | cfg_index (register), cfg_data (value)
//  s       | in  | s_tvalid/s_tready   | s_tuser = mode, s_tdata = random draw
//  m       | out | m_tvalid/m_tready   | m_tdata = target_index, status
//
//  one word goes from acceptance to the output register in these steps:
//  n summing steps, 64 steps of bit-serial restoring remainder of the random
//  value by the weight sum, k walk steps (1 to n) and one to load the output;
//  a sum error skips the remainder and walk steps; s_tready returns after the output load
//  a new word is taken once the previous result sits in the output register,
//  so a stalled result only holds the block when a second result is ready
//  rst_n clears the state, restores the reset weights and empties the output
//  cfg_ready is always high; the user must write registers only while the block is idle, the block does not enforce it
module weighted_random_picker_with_exclusion_core
    import wrp_pkg::*;
#(
    parameter int CLUSTERS = 4
)(
    input  logic                clk,
    input  logic                rst_n,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    // input words
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [63:0]         s_tdata,   // [63:0] random draw
    input  logic [0:0]          s_tuser,   // [0] mode
    // result words
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata    // [1:0] target_index, [3:2] status, [7:4] zero
);

    // targets that can ever be in use
    localparam int NUM_W = (CLUSTERS < MAX_TARGETS) ? CLUSTERS : MAX_TARGETS;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;

    // configuration registers
    logic [2:0]            count_reg;
    logic [WEIGHT_W-1:0]   weight_reg [MAX_TARGETS];

    // block state kept between words
    logic [3:0]            mask_reg;
    logic [1:0]            cur_reg;
    logic [RANDOM_W-1:0]   rand_reg;

    // working registers of one word
    logic [1:0]            idx_reg;
    logic [WEIGHT_W-1:0]   sum_reg;
    logic [WEIGHT_W-1:0]   rem_reg;
    logic [5:0]            bit_cnt_reg;
    logic [1:0]            res_target_reg;
    status_t               res_status_reg;

    // output register
    logic                  m_valid_reg;
    logic [1:0]            out_target_reg;
    status_t               out_status_reg;

    logic [2:0]            n_use;
    logic [3:0]            full_mask;
    logic [3:0]            mask_upd;
    logic                  in_accept;
    logic                  out_load;
    logic                  idx_last;
    logic                  eligible;
    logic [WEIGHT_W-1:0]   w_sel;
    logic [WEIGHT_W:0]     sum_add;
    logic [WEIGHT_W-1:0]   sum_fin;
    logic [WEIGHT_W:0]     rem_shift;
    logic [WEIGHT_W:0]     rem_diff;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'b0000, out_status_reg, out_target_reg};

    // targets in use: zero acts as one, large counts saturate
    always_comb
    begin
        if (count_reg == 3'd0)
        begin
            n_use = 3'd1;
        end
        else if (count_reg > 3'(NUM_W))
        begin
            n_use = 3'(NUM_W);
        end
        else
        begin
            n_use = count_reg;
        end
        for (int i = 0; i < 4; i++)
        begin
            full_mask[i] = (3'(i) < n_use);
        end
    end

    // refresh marks the current target, mask clears once all in use are marked
    always_comb
    begin
        mask_upd = mask_reg | (4'b0001 << cur_reg);
        if ((mask_upd & full_mask) == full_mask)
        begin
            mask_upd = 4'b0000;
        end
    end

    assign idx_last = ({1'b0, idx_reg} == (n_use - 3'd1));
    assign eligible = !mask_reg[idx_reg];
    assign w_sel    = weight_reg[idx_reg];
    assign sum_add  = {1'b0, sum_reg} + {1'b0, w_sel};
    assign sum_fin  = eligible ? sum_add[WEIGHT_W-1:0] : sum_reg;

    // one restoring step: bring in the next random bit, subtract if it fits
    assign rem_shift = {rem_reg, rand_reg[RANDOM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, sum_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (eligible && sum_add[WEIGHT_W])
                begin
                    state_next = ST_DONE;
                end
                else if (idx_last)
                begin
                    state_next = (sum_fin == '0) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (bit_cnt_reg == 6'd0)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (eligible && (rem_reg < w_sel))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control, configuration and kept state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= 3'd1;
            for (int i = 0; i < MAX_TARGETS; i++)
            begin
                weight_reg[i] <= (i == 0) ? WEIGHT_W'(1) : '0;
            end
            mask_reg    <= 4'b0000;
            cur_reg     <= 2'd0;
            rand_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CLUSTER_COUNT)
                begin
                    count_reg <= cfg_data[2:0];
                end
                for (int i = 0; i < NUM_W; i++)
                begin
                    if (cfg_index == (REG_WEIGHT_0 + 3'(i)))
                    begin
                        weight_reg[i] <= cfg_data;
                    end
                end
            end

            if (in_accept)
            begin
                if (s_tuser[0] == 1'b0)
                begin
                    rand_reg <= s_tdata;
                    mask_reg <= 4'b0000;
                end
                else
                begin
                    mask_reg <= mask_upd;
                end
            end
            else if (state_reg == ST_DIV)
            begin
                // rotate, so the value is back in place after 64 steps
                rand_reg <= {rand_reg[RANDOM_W-2:0], rand_reg[RANDOM_W-1]};
            end

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
                if (res_status_reg == STATUS_OK)
                begin
                    cur_reg <= res_target_reg;
                end
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath of one word
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_reg <= 2'd0;
                sum_reg <= '0;
            end
            ST_SUM:
            begin
                if (eligible && sum_add[WEIGHT_W])
                begin
                    res_status_reg <= STATUS_OVERFLOW;
                end
                else
                begin
                    sum_reg <= sum_fin;
                    if (idx_last)
                    begin
                        res_status_reg <= (sum_fin == '0) ? STATUS_ZERO : STATUS_OK;
                        rem_reg        <= '0;
                        bit_cnt_reg    <= 6'd63;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 2'd1;
                    end
                end
            end
            ST_DIV:
            begin
                rem_reg     <= rem_diff[WEIGHT_W] ? rem_shift[WEIGHT_W-1:0]
                                                  : rem_diff[WEIGHT_W-1:0];
                bit_cnt_reg <= bit_cnt_reg - 6'd1;
                idx_reg     <= 2'd0;
            end
            ST_WALK:
            begin
                // first eligible target whose interval holds the remainder
                if (eligible)
                begin
                    if (rem_reg < w_sel)
                    begin
                        res_target_reg <= idx_reg;
                    end
                    else
                    begin
                        rem_reg <= rem_reg - w_sel;
                    end
                end
                idx_reg <= idx_reg + 2'd1;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_status_reg <= res_status_reg;
                    out_target_reg <= (res_status_reg == STATUS_OK) ? res_target_reg
                                                                    : cur_reg;
                end
            end
            default:
            begin
                idx_reg <= 2'd0;
            end
        endcase
    end

    // remainder stays below a nonzero sum through the division
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ((sum_reg != '0) && (rem_reg < sum_reg)))
        else $error("remainder out of range during division");

    // an accepted word starts the weight sum
    a_accept_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_SUM))
        else $error("accepted word did not start summing");

    // a good pick is an eligible target in use
    a_pick_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (res_status_reg == STATUS_OK)) |->
        (({1'b0, res_target_reg} < n_use) && !mask_reg[res_target_reg]))
        else $error("picked target not eligible");

    // the used mask always leaves one target in use eligible
    a_mask_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> ((mask_reg & full_mask) != full_mask))
        else $error("every target excluded");

endmodule

FILE: test/weighted_random_picker_with_exclusion_core_test.sv
// self-checking testbench for the weighted random picker with exclusion
`timescale 1ns / 100ps

module weighted_random_picker_with_exclusion_core_test;
    import wrp_pkg::*;

    localparam int CLUSTERS     = 4;
    localparam int TARGETS_USED = (CLUSTERS < MAX_TARGETS) ? CLUSTERS : MAX_TARGETS;

    // word modes on s_tuser
    localparam logic MODE_NEW     = 1'b0;
    localparam logic MODE_REFRESH = 1'b1;

    // first register index past the weight registers, writes there are dropped
    localparam cfg_index_t REG_SPARE = cfg_index_t'(REG_WEIGHT_0 + MAX_TARGETS);

    // drain time after the last phase, and length of one receiver hold-off
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;
    // quiet cycles allowed: well above one hold-off plus a pick and both gaps
    localparam int QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic        mode;
        logic [63:0] seed;
    } pick_req_t;

    typedef struct packed {
        logic [1:0] target;
        status_t    status;
    } pick_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;     // [63:0] random draw
    logic [0:0]  s_tuser = '0;     // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [1:0] target_index, [3:2] status, [7:4] zero

    // words still to be offered, and picks still to come out
    pick_req_t pending_requests[$];
    pick_res_t expected_picks[$];

    // own copy of the registers and the selection state
    logic [2:0]  mir_count;
    logic [31:0] mir_weight[MAX_TARGETS];
    logic [3:0]  mir_used;
    logic [1:0]  mir_current;
    logic [63:0] mir_stored;

    // knobs driven from the stimulus process
    logic idle_on = 1'b1;
    int   hold_requests = 0;

    int failures = 0;
    int words_queued = 0;
    int words_sent = 0;
    int picks_seen = 0;
    int reg_writes = 0;
    int n_ok = 0;
    int n_overflow = 0;
    int n_zero = 0;

    always #2 clk = ~clk;

    weighted_random_picker_with_exclusion_core #(
        .CLUSTERS (CLUSTERS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // weighted pick over the targets still eligible, one call per accepted word
    function automatic void predict_pick(input logic mode, input logic [63:0] seed);
        int unsigned n;
        logic [3:0]  full;
        logic [63:0] sum;
        logic [63:0] sel;
        logic [63:0] lo;
        status_t     st;
        bit          found;
        pick_res_t   res;
        n = (mir_count == 0) ? 1 : mir_count;
        if (n > TARGETS_USED)
            n = TARGETS_USED;
        full = 4'((1 << n) - 1);
        if (mode == MODE_NEW)
        begin
            mir_stored = seed;
            mir_used   = '0;
        end
        else
        begin
            // a stale current target still gets its bit set
            mir_used[mir_current] = 1'b1;
            if ((mir_used & full) == full)
                mir_used = '0;
        end
        sum = '0;
        st  = STATUS_OK;
        for (int i = 0; i < n; i++)
        begin
            if (!mir_used[i] && st == STATUS_OK)
            begin
                sum += mir_weight[i];
                // overflow is caught before the zero test
                if (sum > 64'hFFFF_FFFF)
                    st = STATUS_OVERFLOW;
            end
        end
        if (st == STATUS_OK && sum == 0)
            st = STATUS_ZERO;
        if (st == STATUS_OK)
        begin
            sel   = mir_stored % sum;
            lo    = '0;
            found = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                if (!mir_used[i] && !found)
                begin
                    if (sel >= lo && sel < lo + mir_weight[i])
                    begin
                        mir_current = 2'(i);
                        found = 1'b1;
                    end
                    lo += mir_weight[i];
                end
            end
            n_ok++;
        end
        else if (st == STATUS_OVERFLOW)
            n_overflow++;
        else
            n_zero++;
        // on error the current target is simply repeated
        res.target = mir_current;
        res.status = st;
        expected_picks.insert(expected_picks.size(), res);
    endfunction

    function automatic void check_pick(input logic [7:0] word);
        pick_res_t want;
        picks_seen++;
        if (expected_picks.size() == 0)
        begin
            $display("%0t: result word %h with nothing expected", $time, word);
            failures++;
        end
        else
        begin
            want = expected_picks.pop_front();
            if (word[1:0] !== want.target)
            begin
                $display("%0t: target_index expected %0d actual %0d",
                         $time, want.target, word[1:0]);
                failures++;
            end
            if (word[3:2] !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, word[3:2]);
                failures++;
            end
        end
    endfunction

    // sender: offers queued words, with random gaps after accepted ones
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        pick_req_t nxt;
        int        gap_left;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_pick(s_tuser[0], s_tdata);
                words_sent++;
            end
            // a word on offer stays put until taken
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    nxt = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.seed;
                    s_tuser  <= nxt.mode;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 18);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks results, stalls in bursts and holds off when asked
    always @(posedge clk or negedge rst_n)
    begin : take_picks
        int stall_left;
        int hold_left;
        int hold_served;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_served = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_pick(m_tdata);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(0, 17);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // register write; cfg_valid stays high so writes can go back to back
    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        if (idx == REG_CLUSTER_COUNT)
            mir_count = val[2:0];
        else if (idx >= REG_WEIGHT_0 && idx < REG_SPARE)
            mir_weight[2'(idx - REG_WEIGHT_0)] = val;
        reg_writes++;
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_word(input logic mode, input logic [63:0] seed);
        pick_req_t req;
        req.mode = mode;
        req.seed = seed;
        pending_requests.insert(pending_requests.size(), req);
        words_queued++;
    endtask

    // block is idle once every queued word has come back as a result
    task automatic wait_idle();
        while (picks_seen < words_queued)
            @(posedge clk);
    endtask

    function automatic logic [63:0] rand_seed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'($urandom_range(0, 1000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 19)) inside
            [0:1]:   return '0;
            2:       return '1;
            [3:5]:   return $urandom;
            [6:10]:  return $urandom_range(0, 1 << 28);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    // random settings, then request/refresh runs with some stray words mixed in
    task automatic random_phase(input int n_words, input logic idle, input bit hold);
        logic [2:0] cnt;
        int         queued;
        int         refreshes;
        case ($urandom_range(0, 7))
            0:       cnt = 3'd0;
            1:       cnt = 3'($urandom_range(5, 7));
            2:       cnt = 3'd1;
            default: cnt = 3'($urandom_range(2, 4));
        endcase
        write_reg(REG_CLUSTER_COUNT, {29'($urandom), cnt});
        for (int i = 0; i < MAX_TARGETS; i++)
            write_reg(cfg_index_t'(REG_WEIGHT_0 + i), rand_weight());
        if ($urandom_range(0, 3) == 0)
            write_reg(cfg_index_t'($urandom_range(REG_SPARE, 7)), $urandom);
        end_writes();
        idle_on <= idle;
        if (hold)
            hold_requests <= hold_requests + 1;
        queued = 0;
        while (queued < n_words)
        begin
            if ($urandom_range(0, 19) < 17)
            begin
                queue_word(MODE_NEW, rand_seed());
                refreshes = $urandom_range(0, 6);
                for (int r = 0; r < refreshes; r++)
                    queue_word(MODE_REFRESH, rand_seed());
                queued += refreshes + 1;
            end
            else
            begin
                queue_word(1'($urandom), rand_seed());
                queued++;
            end
        end
        wait_idle();
    endtask

    initial
    begin
        mir_count   = 3'd1;
        mir_weight  = '{32'd1, 32'd0, 32'd0, 32'd0};
        mir_used    = '0;
        mir_current = '0;
        mir_stored  = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: only target 0, refresh before any request
        queue_word(MODE_REFRESH, 64'h0123_4567_89ab_cdef);
        queue_word(MODE_NEW, '0);
        queue_word(MODE_NEW, '1);
        queue_word(MODE_REFRESH, '0);
        wait_idle();

        // zero weight sum
        write_reg(cfg_index_t'(REG_WEIGHT_0), '0);
        end_writes();
        queue_word(MODE_NEW, 64'd5);
        queue_word(MODE_REFRESH, '0);
        wait_idle();

        // four maximum weights overflow the sum
        write_reg(REG_CLUSTER_COUNT, 32'd4);
        for (int i = 0; i < MAX_TARGETS; i++)
            write_reg(cfg_index_t'(REG_WEIGHT_0 + i), '1);
        end_writes();
        queue_word(MODE_NEW, 64'hdead_beef_0000_0001);
        queue_word(MODE_REFRESH, '0);
        wait_idle();

        // small weights: walk the intervals, then refresh until the mask clears
        for (int i = 0; i < MAX_TARGETS; i++)
            write_reg(cfg_index_t'(REG_WEIGHT_0 + i), 32'(i + 1));
        end_writes();
        queue_word(MODE_NEW, 64'd0);
        queue_word(MODE_NEW, 64'd1);
        queue_word(MODE_NEW, 64'd9);
        repeat (5) queue_word(MODE_REFRESH, '1);
        wait_idle();

        // pick target 3, then shrink the count so the current target is stale
        write_reg(cfg_index_t'(REG_WEIGHT_0), '0);
        write_reg(cfg_index_t'(REG_WEIGHT_0 + 1), '0);
        write_reg(cfg_index_t'(REG_WEIGHT_0 + 2), '0);
        write_reg(cfg_index_t'(REG_WEIGHT_0 + 3), 32'd5);
        end_writes();
        queue_word(MODE_NEW, 64'd7);
        wait_idle();
        write_reg(REG_CLUSTER_COUNT, 32'd2);
        write_reg(cfg_index_t'(REG_WEIGHT_0), 32'd3);
        write_reg(cfg_index_t'(REG_WEIGHT_0 + 1), 32'd4);
        write_reg(REG_SPARE, '1);
        end_writes();
        repeat (3) queue_word(MODE_REFRESH, '0);
        wait_idle();

        // only remaining eligible target has no weight
        write_reg(cfg_index_t'(REG_WEIGHT_0), 32'd5);
        write_reg(cfg_index_t'(REG_WEIGHT_0 + 1), '0);
        end_writes();
        queue_word(MODE_NEW, 64'd3);
        queue_word(MODE_REFRESH, '0);
        queue_word(MODE_REFRESH, '0);
        wait_idle();

        // count of zero acts as one, count of seven saturates
        write_reg(REG_CLUSTER_COUNT, 32'hffff_fff8);
        end_writes();
        queue_word(MODE_NEW, 64'h8000_0000_0000_0000);
        wait_idle();
        write_reg(REG_CLUSTER_COUNT, 32'd7);
        write_reg(cfg_index_t'(REG_WEIGHT_0 + 2), 32'h8000_0000);
        end_writes();
        queue_word(MODE_NEW, '1);
        queue_word(MODE_REFRESH, '0);
        wait_idle();

        // random settings; phase 5 holds off the receiver to fill the pipe
        for (int p = 0; p < 11; p++)
            random_phase(110, (p % 4) != 3, p == 5);

        // closing stretch with no idling on either side
        random_phase(130, 1'b0, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d words sent, %0d results checked, %0d register writes",
                 words_sent, picks_seen, reg_writes);
        $display("picks: %0d ok, %0d sum overflow, %0d sum zero; %0d receiver hold-off(s)",
                 n_ok, n_overflow, n_zero, hold_requests);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
